### rtl/cslu_pkg.sv
// Shared types and constants for the C string literal decoder.
`timescale 1ns / 1ps

package cslu_pkg;

    // Escape class held between source bytes
    typedef enum logic [2:0] {
        CLS_LIT = 3'd0,
        CLS_BSL = 3'd1,
        CLS_OCT = 3'd2,
        CLS_HXI = 3'd3,
        CLS_HEX = 3'd4
    } cls_t;

    // Error codes carried on a done beat
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_PARSE   = 3'd1;
    localparam logic [2:0] ERR_VALUE   = 3'd2;
    localparam logic [2:0] ERR_HIGH    = 3'd3;
    localparam logic [2:0] ERR_OVERRUN = 3'd4;

    // Register indexes on the APB port (byte address bit 2)
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_REJECT   = 1'b1;

    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    // One result beat
    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        done_res;
        logic [2:0]  error_code;
        logic [15:0] decoded_length;
        logic        last_of_run;
    } result_t;

    // Configuration seen by the decoder
    typedef struct packed {
        logic [15:0] dest_capacity;
        logic        reject_high_bytes;
    } cfg_t;

    // Up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] n;
        result_t    i0;
        result_t    i1;
    } push_t;

    // Result queue status
    typedef struct packed {
        logic [2:0] level;
        logic       room;
    } qstat_t;

endpackage

### rtl/c_string_literal_unescaper.sv
// Top level of the C string literal decoder.
// Path: a byte accepted into the input register is decoded combinationally from it once the
//   result queue has room for two beats; its result beats are written into the queue and offered from there.
// Throughput: one source byte per cycle while each byte gives at most one beat and the result
//   channel does not stall; bytes giving two beats are paced by the four-beat result queue.
// Reset: string idle, literal class, length zero, queue empty, capacity 65535,
//   high byte rejection on.
`timescale 1ns / 1ps

module c_string_literal_unescaper
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Source bytes
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  in_byte,
    input  logic        start_of_string,
    input  logic        end_of_source,
    // Results
    output logic        result_valid,
    input  logic        result_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        done_res,
    output logic [2:0]  error_code,
    output logic [15:0] decoded_length,
    output logic        last_of_run
);

    cslu_pkg::cfg_t    cfg;
    cslu_pkg::push_t   push;
    cslu_pkg::qstat_t  qstat;
    cslu_pkg::result_t result;

    cslu_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cslu_decode
    #(
        .LENGTH_BITS (LENGTH_BITS)
    )
    u_decode
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .in_byte         (in_byte),
        .start_of_string (start_of_string),
        .end_of_source   (end_of_source),
        .cfg             (cfg),
        .room            (qstat.room),
        .push            (push)
    );

    cslu_outq u_outq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .stat         (qstat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign out_valid      = result.out_valid;
    assign out_byte       = result.out_byte;
    assign done_res       = result.done_res;
    assign error_code     = result.error_code;
    assign decoded_length = result.decoded_length;
    assign last_of_run    = result.last_of_run;

`ifndef SYNTHESIS
    // Queue never overfills
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.level <= 3'd4)
        else $error("result queue overfilled");

    // Writes only land when there was room for two beats
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> qstat.room)
        else $error("push without queue room");

    // A done beat is always the final beat of its byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && done_res) |-> last_of_run)
        else $error("done beat not last of run");

    // An error beat ends the string and carries no byte
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && error_code != cslu_pkg::ERR_NONE) |-> (done_res && !out_valid))
        else $error("error beat malformed");
`endif

endmodule

### rtl/cslu_cfg.sv
// APB configuration registers: decoded length capacity and high byte rejection.
`timescale 1ns / 1ps

module cslu_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cslu_pkg::cfg_t     cfg
);

    logic [15:0] capacity_reg;
    logic        reject_reg;
    logic        wr_en;
    logic        sel_reg_idx;

    assign pready      = 1'b1;
    assign sel_reg_idx = paddr[2];
    assign wr_en       = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= cslu_pkg::CAPACITY_RESET;
            reject_reg   <= 1'b1;
        end
        else if (wr_en)
        begin
            if (sel_reg_idx == cslu_pkg::REG_CAPACITY)
            begin
                capacity_reg <= pwdata[15:0];
            end
            else
            begin
                reject_reg <= pwdata[0];
            end
        end
    end

    // Read back
    always_comb
    begin
        if (sel_reg_idx == cslu_pkg::REG_REJECT)
        begin
            prdata = {31'b0, reject_reg};
        end
        else
        begin
            prdata = {16'b0, capacity_reg};
        end
    end

    assign cfg.dest_capacity     = capacity_reg;
    assign cfg.reject_high_bytes = reject_reg;

endmodule

### rtl/cslu_decode.sv
// Input register and single-pass decode of one source byte into up to two results.
`timescale 1ns / 1ps

module cslu_decode
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [7:0]        in_byte,
    input  logic              start_of_string,
    input  logic              end_of_source,
    input  cslu_pkg::cfg_t    cfg,
    input  logic              room,
    output cslu_pkg::push_t   push
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_X     = 8'h78;

    // Working copy of the parse state while one byte is decoded
    typedef struct packed {
        logic                   phase;
        cslu_pkg::cls_t         cls;
        logic [7:0]             val;
        logic                   ovf;
        logic [1:0]             cnt;
        logic [LENGTH_BITS-1:0] len;
        logic                   ended;
        logic [1:0]             n;
        cslu_pkg::result_t      i0;
        cslu_pkg::result_t      i1;
    } ctx_t;

    // Input register
    logic       full_reg;
    logic       full_next;
    logic [7:0] byte_reg;
    logic       sos_reg;
    logic       eos_reg;
    logic       accept;
    logic       advance;

    // Parse state
    logic                   phase_reg;
    cslu_pkg::cls_t         cls_reg;
    logic [7:0]             val_reg;
    logic                   ovf_reg;
    logic [1:0]             cnt_reg;
    logic [LENGTH_BITS-1:0] len_reg;

    ctx_t ctx;

    // Low 16 bits of the length counter, zero-extended when narrower
    function automatic logic [15:0] len16(input logic [LENGTH_BITS-1:0] l);
        logic [LENGTH_BITS+15:0] ext;
        ext = {16'b0, l};
        return ext[15:0];
    endfunction

    // {digit seen, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // {simple escape seen, decoded byte}
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h61:   r = {1'b1, 8'd7};
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            8'h6E:   r = {1'b1, 8'd10};
            8'h72:   r = {1'b1, 8'd13};
            8'h74:   r = {1'b1, 8'd9};
            8'h76:   r = {1'b1, 8'd11};
            8'h22,
            8'h3F,
            8'h27,
            8'h5C:   r = {1'b1, c};
            default: r = 9'b0;
        endcase
        return r;
    endfunction

    function automatic ctx_t f_put(input ctx_t c, input logic v, input logic [7:0] b,
                                   input logic d, input logic [2:0] e);
        cslu_pkg::result_t it;
        it.out_valid      = v;
        it.out_byte       = b;
        it.done_res       = d;
        it.error_code     = e;
        it.decoded_length = len16(c.len);
        it.last_of_run    = 1'b0;
        if (c.n == 2'd0)
        begin
            c.i0 = it;
            c.n  = 2'd1;
        end
        else if (c.n == 2'd1)
        begin
            c.i1 = it;
            c.n  = 2'd2;
        end
        return c;
    endfunction

    function automatic ctx_t f_clear(input ctx_t c);
        c.cls = cslu_pkg::CLS_LIT;
        c.val = 8'd0;
        c.ovf = 1'b0;
        c.cnt = 2'd0;
        return c;
    endfunction

    // Done beat ends the string
    function automatic ctx_t f_finish(input ctx_t c, input logic [2:0] e);
        c       = f_put(c, 1'b0, 8'd0, 1'b1, e);
        c       = f_clear(c);
        c.phase = 1'b0;
        c.ended = 1'b1;
        return c;
    endfunction

    function automatic ctx_t f_send(input ctx_t c, input logic [7:0] b,
                                    input cslu_pkg::cfg_t g);
        logic [LENGTH_BITS+15:0] le;
        logic [LENGTH_BITS+15:0] ce;
        le = {16'b0, c.len};
        ce = {{LENGTH_BITS{1'b0}}, g.dest_capacity};
        if (le >= ce || (&c.len))
        begin
            c = f_finish(c, cslu_pkg::ERR_OVERRUN);
        end
        else
        begin
            c.len = c.len + LENGTH_BITS'(1);
            c     = f_put(c, 1'b1, b, 1'b0, cslu_pkg::ERR_NONE);
        end
        return c;
    endfunction

    function automatic ctx_t f_literal(input ctx_t c, input logic [7:0] b,
                                       input cslu_pkg::cfg_t g);
        if (b == CH_QUOTE)
        begin
            c = f_finish(c, cslu_pkg::ERR_NONE);
        end
        else if (b == CH_BSL)
        begin
            c.cls = cslu_pkg::CLS_BSL;
        end
        else if (b == CH_NL)
        begin
            c = f_finish(c, cslu_pkg::ERR_PARSE);
        end
        else
        begin
            c = f_send(c, b, g);
        end
        return c;
    endfunction

    // Close a numeric escape and check its value
    function automatic ctx_t f_end_escape(input ctx_t c, input cslu_pkg::cfg_t g);
        logic [7:0] v;
        logic       o;
        v = c.val;
        o = c.ovf;
        c = f_clear(c);
        if (o)
        begin
            c = f_finish(c, cslu_pkg::ERR_VALUE);
        end
        else if (g.reject_high_bytes && v[7])
        begin
            c = f_finish(c, cslu_pkg::ERR_HIGH);
        end
        else
        begin
            c = f_send(c, v, g);
        end
        return c;
    endfunction

    // Input register handshake
    assign advance    = full_reg & room;
    assign item_stall = full_reg & ~room;
    assign accept     = item_valid & ~item_stall;

    always_comb
    begin
        full_next = full_reg;
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (advance)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
            sos_reg  <= start_of_string;
            eos_reg  <= end_of_source;
        end
    end

    // Decode one byte
    always_comb
    begin
        logic [4:0] hd;
        logic [8:0] se;
        logic       is_oct;

        hd     = hex_digit(byte_reg);
        se     = simple_escape(byte_reg);
        is_oct = (byte_reg[7:3] == 5'b00110);

        ctx.phase = phase_reg;
        ctx.cls   = cls_reg;
        ctx.val   = val_reg;
        ctx.ovf   = ovf_reg;
        ctx.cnt   = cnt_reg;
        ctx.len   = len_reg;
        ctx.ended = 1'b0;
        ctx.n     = 2'd0;
        ctx.i0    = '0;
        ctx.i1    = '0;

        if (sos_reg)
        begin
            ctx       = f_clear(ctx);
            ctx.len   = '0;
            ctx.phase = 1'b1;
            if (byte_reg != CH_QUOTE || eos_reg)
            begin
                ctx = f_finish(ctx, cslu_pkg::ERR_PARSE);
            end
        end
        else if (ctx.phase)
        begin
            case (ctx.cls)
                cslu_pkg::CLS_BSL:
                begin
                    if (se[8])
                    begin
                        ctx.cls = cslu_pkg::CLS_LIT;
                        ctx     = f_send(ctx, se[7:0], cfg);
                    end
                    else if (is_oct)
                    begin
                        ctx     = f_clear(ctx);
                        ctx.cls = cslu_pkg::CLS_OCT;
                        ctx.val = {5'b0, byte_reg[2:0]};
                        ctx.cnt = 2'd1;
                    end
                    else if (byte_reg == CH_X)
                    begin
                        ctx     = f_clear(ctx);
                        ctx.cls = cslu_pkg::CLS_HXI;
                    end
                    else
                    begin
                        ctx = f_finish(ctx, cslu_pkg::ERR_PARSE);
                    end
                end
                cslu_pkg::CLS_OCT:
                begin
                    if (is_oct && ctx.cnt != 2'd3)
                    begin
                        ctx.ovf = ctx.ovf | (ctx.val[7:5] != 3'd0);
                        ctx.val = {ctx.val[4:0], byte_reg[2:0]};
                        ctx.cnt = ctx.cnt + 2'd1;
                    end
                    else
                    begin
                        ctx = f_end_escape(ctx, cfg);
                        if (!ctx.ended)
                        begin
                            ctx = f_literal(ctx, byte_reg, cfg);
                        end
                    end
                end
                cslu_pkg::CLS_HXI:
                begin
                    if (hd[4])
                    begin
                        ctx.cls = cslu_pkg::CLS_HEX;
                        ctx.val = {4'b0, hd[3:0]};
                    end
                    else
                    begin
                        ctx = f_finish(ctx, cslu_pkg::ERR_PARSE);
                    end
                end
                cslu_pkg::CLS_HEX:
                begin
                    if (hd[4])
                    begin
                        ctx.ovf = ctx.ovf | (ctx.val[7:4] != 4'd0);
                        ctx.val = {ctx.val[3:0], hd[3:0]};
                    end
                    else
                    begin
                        ctx = f_end_escape(ctx, cfg);
                        if (!ctx.ended)
                        begin
                            ctx = f_literal(ctx, byte_reg, cfg);
                        end
                    end
                end
                default:
                begin
                    ctx.cls = cslu_pkg::CLS_LIT;
                    ctx     = f_literal(ctx, byte_reg, cfg);
                end
            endcase

            // Source ran out before the closing quote
            if (!ctx.ended && eos_reg)
            begin
                if (ctx.cls == cslu_pkg::CLS_OCT || ctx.cls == cslu_pkg::CLS_HEX)
                begin
                    ctx = f_end_escape(ctx, cfg);
                end
                if (!ctx.ended)
                begin
                    if (ctx.n == 2'd2)
                    begin
                        ctx.n   = 2'd1;
                        ctx.len = ctx.len - LENGTH_BITS'(1);
                    end
                    ctx = f_finish(ctx, cslu_pkg::ERR_PARSE);
                end
            end
        end

        // Mark the final beat of this byte
        if (ctx.n == 2'd2)
        begin
            ctx.i1.last_of_run = 1'b1;
        end
        else if (ctx.n == 2'd1)
        begin
            ctx.i0.last_of_run = 1'b1;
        end
    end

    // Parse state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            cls_reg   <= cslu_pkg::CLS_LIT;
            val_reg   <= 8'd0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= 2'd0;
            len_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= ctx.phase;
            cls_reg   <= ctx.cls;
            val_reg   <= ctx.val;
            ovf_reg   <= ctx.ovf;
            cnt_reg   <= ctx.cnt;
            len_reg   <= ctx.len;
        end
    end

    assign push.n  = advance ? ctx.n : 2'd0;
    assign push.i0 = ctx.i0;
    assign push.i1 = ctx.i1;

endmodule

### rtl/cslu_outq.sv
// Four-entry result queue: up to two beats written, one beat read per cycle unless the result channel stalls.
`timescale 1ns / 1ps

module cslu_outq
(
    input  logic                clk,
    input  logic                rst_n,
    input  cslu_pkg::push_t     push,
    output cslu_pkg::qstat_t    stat,
    output logic                result_valid,
    input  logic                result_stall,
    output cslu_pkg::result_t   result
);

    cslu_pkg::result_t q_mem [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] level_reg;
    logic [2:0] level_next;
    logic       pop;

    assign result_valid = (level_reg != 3'd0);
    assign pop          = result_valid & ~result_stall;
    assign result       = q_mem[rp_reg];
    assign level_next   = level_reg + {1'b0, push.n} - {2'b0, pop};

    assign stat.level = level_reg;
    assign stat.room  = (level_reg <= 3'd2);

    // Entry writes
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            q_mem[wp_reg] <= push.i0;
        end
        if (push.n == 2'd2)
        begin
            q_mem[wp_reg + 2'd1] <= push.i1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 2'd0;
            rp_reg    <= 2'd0;
            level_reg <= 3'd0;
        end
        else
        begin
            wp_reg    <= wp_reg + push.n;
            rp_reg    <= rp_reg + {1'b0, pop};
            level_reg <= level_next;
        end
    end

endmodule
